// ----- rtl/kmcq_pkg.sv -----
// shared types, constants and helper functions of the color quantizer
package kmcq_pkg;

    localparam int MAX_PIXELS   = 4096;
    localparam int MAX_CLUSTERS = 16;
    localparam int ADDR_W       = 12;
    localparam int CNT_W        = 13;
    localparam int SUM_W        = 20;
    localparam int DIST_W       = 18;
    localparam int COST_W       = 30;
    localparam int CL_W         = 4;
    localparam int K_W          = 5;

    localparam logic [COST_W-1:0] COST_MAX  = 30'h3FFF_FFFF;
    localparam logic [15:0]       LFSR_TAPS = 16'hB400;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_RUN  = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    localparam logic [1:0] KIND_CENT   = 2'd0;
    localparam logic [1:0] KIND_ASSIGN = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [1:0] REG_CLUSTERS = 2'd0;
    localparam logic [1:0] REG_ITER     = 2'd1;
    localparam logic [1:0] REG_SEED     = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] pixel_index;
    } cmd_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [11:0]       slot;
        logic [7:0]        out_red;
        logic [7:0]        out_green;
        logic [7:0]        out_blue;
        logic [3:0]        cluster;
        logic [COST_W-1:0] total_cost;
        logic              last;
    } result_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_READ,
        S_PICK_DIV,
        S_PICK_WAIT,
        S_PICK_WR,
        S_SNAP,
        S_ASG_RD,
        S_ASG_CMP,
        S_SUM_RD,
        S_SUM_ACC,
        S_DIV_GO,
        S_DIV_WAIT,
        S_CHECK,
        S_COST_RD,
        S_COST_ACC,
        S_EMIT
    } state_t;

    function automatic logic [DIST_W-1:0] sq_dist(input logic [23:0] a, input logic [23:0] b);
        logic [DIST_W-1:0] s;
        logic [7:0]        d;
        s = '0;
        for (int i = 0; i < 3; i++)
        begin
            d = (a[i*8 +: 8] > b[i*8 +: 8]) ? a[i*8 +: 8] - b[i*8 +: 8]
                                            : b[i*8 +: 8] - a[i*8 +: 8];
            s = s + DIST_W'(d) * DIST_W'(d);
        end
        return s;
    endfunction

    function automatic logic [15:0] lfsr_adv(input logic [15:0] v);
        return v[0] ? ((v >> 1) ^ LFSR_TAPS) : (v >> 1);
    endfunction

endpackage

// ----- rtl/kmcq_ram.sv -----
// generic single-write, single-read ram with registered read data
module kmcq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ----- rtl/kmcq_div.sv -----
// three-lane restoring divider sharing one divisor, one quotient bit per cycle
module kmcq_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [kmcq_pkg::SUM_W-1:0]    dividend [3],
    input  logic [kmcq_pkg::CNT_W-1:0]    divisor,
    output logic                          done,
    output logic [kmcq_pkg::SUM_W-1:0]    quot [3],
    output logic [kmcq_pkg::CNT_W-1:0]    rem [3]
);
    import kmcq_pkg::*;

    logic [SUM_W-1:0] q_reg [3];
    logic [CNT_W-1:0] r_reg [3];
    logic [CNT_W-1:0] d_reg;
    logic [4:0]       cnt_reg;
    logic             run_reg;
    logic             done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 5'(SUM_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            d_reg <= divisor;
            for (int i = 0; i < 3; i++)
            begin
                q_reg[i] <= dividend[i];
                r_reg[i] <= '0;
            end
        end
        else if (run_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if ({r_reg[i], q_reg[i][SUM_W-1]} >= {1'b0, d_reg})
                begin
                    r_reg[i] <= CNT_W'({r_reg[i], q_reg[i][SUM_W-1]} - {1'b0, d_reg});
                    q_reg[i] <= {q_reg[i][SUM_W-2:0], 1'b1};
                end
                else
                begin
                    r_reg[i] <= {r_reg[i][CNT_W-2:0], q_reg[i][SUM_W-1]};
                    q_reg[i] <= {q_reg[i][SUM_W-2:0], 1'b0};
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;
endmodule

// ----- rtl/kmeans_color_quantizer_top.sv -----
// Lloyd k-means color quantizer over a stored set of RGB pixels
// Loads are written directly from idle and may follow each other in every cycle. A read
// of a pixel's cluster answers through S_READ, an error answer comes straight from idle.
// A run is bounded by the pixel ram port: picking reduces an lfsr index with the 20-step
// divider for each centroid, then each round takes a snapshot, an assignment pass, a mean
// pass (an empty cluster skips the divider) and a check, then a pass sums the cost and a
// last one hands out the centroids. Results appear on result for one cycle each, marked
// by strobe; the receiver cannot stall, and busy drops in the cycle that carries the last
// transfer.
module kmeans_color_quantizer_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  kmcq_pkg::cmd_t    cmd,
    output logic              strobe,
    output kmcq_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data
);
    import kmcq_pkg::*;

    state_t state_reg, state_next;

    logic [K_W-1:0]    clusters_reg;
    logic [7:0]        iter_lim_reg;
    logic [15:0]       lfsr_reg, lfsr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic [7:0]        rounds_reg, rounds_next;
    logic [7:0]        it_reg, it_next;
    logic [CL_W-1:0]   c_reg, c_next;
    logic [ADDR_W-1:0] j_reg, j_next;
    logic [CL_W-1:0]   best_reg, best_next;
    logic [DIST_W-1:0] bestd_reg, bestd_next;
    logic [SUM_W-1:0]  sum_reg [3];
    logic [SUM_W-1:0]  sum_next [3];
    logic [CNT_W-1:0]  mem_reg, mem_next;
    logic [COST_W-1:0] cost_reg, cost_next;
    logic [23:0]       cent_reg [MAX_CLUSTERS];
    logic [23:0]       prev_reg [MAX_CLUSTERS];
    logic              strobe_reg, strobe_next;
    result_t           res_reg, res_next;

    logic              px_we, px_re, cl_we, cl_re;
    logic [ADDR_W-1:0] px_waddr, px_raddr, cl_waddr, cl_raddr;
    logic [23:0]       px_wdata, px_rdata;
    logic [CL_W-1:0]   cl_wdata, cl_rdata;

    logic              div_start, div_done;
    logic [SUM_W-1:0]  div_a [3];
    logic [SUM_W-1:0]  div_q [3];
    logic [CNT_W-1:0]  div_r [3];
    logic [CNT_W-1:0]  div_d;

    logic              accept, cent_we, snap;
    logic [23:0]       cent_wdata;
    logic [CL_W-1:0]   dist_idx;
    logic [DIST_W-1:0] pix_dist;
    logic              last_j, last_c, same;
    logic [K_W-1:0]    k_clamp;
    logic [COST_W:0]   cost_sum;

    kmcq_ram #(.WIDTH(24), .DEPTH(MAX_PIXELS)) u_px_ram (
        .clk(clk), .we(px_we), .waddr(px_waddr), .wdata(px_wdata),
        .re(px_re), .raddr(px_raddr), .rdata(px_rdata)
    );

    kmcq_ram #(.WIDTH(CL_W), .DEPTH(MAX_PIXELS)) u_cl_ram (
        .clk(clk), .we(cl_we), .waddr(cl_waddr), .wdata(cl_wdata),
        .re(cl_re), .raddr(cl_raddr), .rdata(cl_rdata)
    );

    kmcq_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
        .divisor(div_d), .done(div_done), .quot(div_q), .rem(div_r)
    );

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign strobe    = strobe_reg;
    assign result    = res_reg;

    assign dist_idx = (state_reg == S_COST_ACC) ? cl_rdata : c_reg;
    assign pix_dist = sq_dist(px_rdata, cent_reg[dist_idx]);
    assign last_j   = ({1'b0, j_reg} + CNT_W'(1)) == count_reg;
    assign last_c   = ({1'b0, c_reg} + K_W'(1)) == k_reg;
    assign cost_sum = {1'b0, cost_reg} + (COST_W+1)'(pix_dist);

    always_comb
    begin
        k_clamp = (clusters_reg == '0) ? K_W'(1)
                : (clusters_reg > K_W'(MAX_CLUSTERS)) ? K_W'(MAX_CLUSTERS) : clusters_reg;
        if ({{(CNT_W-K_W){1'b0}}, k_clamp} > count_reg)
        begin
            k_clamp = K_W'(count_reg);
        end
    end

    always_comb
    begin
        same = 1'b1;
        for (int i = 0; i < MAX_CLUSTERS; i++)
        begin
            if ((K_W'(i) < k_reg) && (cent_reg[i] != prev_reg[i]))
            begin
                same = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            clusters_reg <= K_W'(4);
            iter_lim_reg <= 8'd16;
            lfsr_reg     <= 16'd44257;
            count_reg    <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            strobe_reg <= strobe_next;
            lfsr_reg   <= lfsr_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_CLUSTERS: clusters_reg <= cfg_data[K_W-1:0];
                    REG_ITER:     iter_lim_reg <= cfg_data[7:0];
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        rounds_reg <= rounds_next;
        it_reg     <= it_next;
        c_reg      <= c_next;
        j_reg      <= j_next;
        best_reg   <= best_next;
        bestd_reg  <= bestd_next;
        sum_reg    <= sum_next;
        mem_reg    <= mem_next;
        cost_reg   <= cost_next;
        res_reg    <= res_next;
        if (cent_we)
        begin
            cent_reg[c_reg] <= cent_wdata;
        end
        if (snap)
        begin
            prev_reg <= cent_reg;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        lfsr_next   = lfsr_reg;
        k_next      = k_reg;
        rounds_next = rounds_reg;
        it_next     = it_reg;
        c_next      = c_reg;
        j_next      = j_reg;
        best_next   = best_reg;
        bestd_next  = bestd_reg;
        sum_next    = sum_reg;
        mem_next    = mem_reg;
        cost_next   = cost_reg;
        strobe_next = 1'b0;
        res_next    = res_reg;
        px_we       = 1'b0;
        px_waddr    = count_reg[ADDR_W-1:0];
        px_wdata    = {cmd.red, cmd.green, cmd.blue};
        px_re       = 1'b0;
        px_raddr    = j_reg;
        cl_we       = 1'b0;
        cl_waddr    = j_reg;
        cl_wdata    = best_reg;
        cl_re       = 1'b0;
        cl_raddr    = j_reg;
        div_start   = 1'b0;
        div_a       = sum_reg;
        div_d       = mem_reg;
        cent_we     = 1'b0;
        cent_wdata  = px_rdata;
        snap        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.mode)
                        MODE_LOAD:
                        begin
                            if (count_reg < CNT_W'(MAX_PIXELS))
                            begin
                                px_we      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        MODE_RUN:
                        begin
                            if (count_reg == '0)
                            begin
                                strobe_next = 1'b1;
                                res_next    = '0;
                                res_next.kind = KIND_ERROR;
                                res_next.last = 1'b1;
                            end
                            else
                            begin
                                k_next      = k_clamp;
                                rounds_next = (iter_lim_reg == '0) ? 8'd1 : iter_lim_reg;
                                c_next      = '0;
                                state_next  = S_PICK_DIV;
                            end
                        end
                        MODE_READ:
                        begin
                            res_next      = '0;
                            res_next.slot = cmd.pixel_index;
                            res_next.last = 1'b1;
                            if ({1'b0, cmd.pixel_index} >= count_reg)
                            begin
                                strobe_next   = 1'b1;
                                res_next.kind = KIND_ERROR;
                            end
                            else
                            begin
                                res_next.kind = KIND_ASSIGN;
                                cl_re         = 1'b1;
                                cl_raddr      = cmd.pixel_index;
                                state_next    = S_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_READ:
            begin
                strobe_next      = 1'b1;
                res_next.cluster = cl_rdata;
                state_next       = S_IDLE;
            end
            S_PICK_DIV:
            begin
                lfsr_next = lfsr_adv(lfsr_reg);
                div_start = 1'b1;
                div_a[0]  = SUM_W'(lfsr_next);
                div_a[1]  = '0;
                div_a[2]  = '0;
                div_d     = count_reg;
                state_next = S_PICK_WAIT;
            end
            S_PICK_WAIT:
            begin
                if (div_done)
                begin
                    px_re      = 1'b1;
                    px_raddr   = div_r[0][ADDR_W-1:0];
                    state_next = S_PICK_WR;
                end
            end
            S_PICK_WR:
            begin
                cent_we = 1'b1;
                if (last_c)
                begin
                    it_next    = '0;
                    state_next = S_SNAP;
                end
                else
                begin
                    c_next     = c_reg + CL_W'(1);
                    state_next = S_PICK_DIV;
                end
            end
            S_SNAP:
            begin
                snap       = 1'b1;
                j_next     = '0;
                c_next     = '0;
                state_next = S_ASG_RD;
            end
            S_ASG_RD:
            begin
                px_re      = 1'b1;
                c_next     = '0;
                state_next = S_ASG_CMP;
            end
            S_ASG_CMP:
            begin
                if (c_reg == '0 || pix_dist < bestd_reg)
                begin
                    best_next  = c_reg;
                    bestd_next = pix_dist;
                end
                if (last_c)
                begin
                    cl_we    = 1'b1;
                    cl_wdata = best_next;
                    if (last_j)
                    begin
                        j_next     = '0;
                        c_next     = '0;
                        mem_next   = '0;
                        sum_next   = '{default: '0};
                        state_next = S_SUM_RD;
                    end
                    else
                    begin
                        j_next     = j_reg + ADDR_W'(1);
                        state_next = S_ASG_RD;
                    end
                end
                else
                begin
                    c_next = c_reg + CL_W'(1);
                end
            end
            S_SUM_RD:
            begin
                px_re      = 1'b1;
                cl_re      = 1'b1;
                state_next = S_SUM_ACC;
            end
            S_SUM_ACC:
            begin
                if (cl_rdata == c_reg)
                begin
                    mem_next = mem_reg + CNT_W'(1);
                    for (int i = 0; i < 3; i++)
                    begin
                        sum_next[i] = sum_reg[i] + SUM_W'(px_rdata[(2-i)*8 +: 8]);
                    end
                end
                if (last_j)
                begin
                    state_next = (mem_next == '0) ? S_CHECK : S_DIV_GO;
                    if (mem_next == '0 && !last_c)
                    begin
                        c_next     = c_reg + CL_W'(1);
                        j_next     = '0;
                        mem_next   = '0;
                        sum_next   = '{default: '0};
                        state_next = S_SUM_RD;
                    end
                end
                else
                begin
                    j_next     = j_reg + ADDR_W'(1);
                    state_next = S_SUM_RD;
                end
            end
            S_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    cent_we    = 1'b1;
                    cent_wdata = {div_q[0][7:0], div_q[1][7:0], div_q[2][7:0]};
                    if (last_c)
                    begin
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        c_next     = c_reg + CL_W'(1);
                        j_next     = '0;
                        mem_next   = '0;
                        sum_next   = '{default: '0};
                        state_next = S_SUM_RD;
                    end
                end
            end
            S_CHECK:
            begin
                if (same || ({1'b0, it_reg} + 9'd1) >= {1'b0, rounds_reg})
                begin
                    j_next     = '0;
                    cost_next  = '0;
                    state_next = S_COST_RD;
                end
                else
                begin
                    it_next    = it_reg + 8'd1;
                    state_next = S_SNAP;
                end
            end
            S_COST_RD:
            begin
                px_re      = 1'b1;
                cl_re      = 1'b1;
                state_next = S_COST_ACC;
            end
            S_COST_ACC:
            begin
                // saturate at the top of the cost field
                cost_next = (cost_sum > {1'b0, COST_MAX}) ? COST_MAX : cost_sum[COST_W-1:0];
                if (last_j)
                begin
                    c_next     = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    j_next     = j_reg + ADDR_W'(1);
                    state_next = S_COST_RD;
                end
            end
            S_EMIT:
            begin
                strobe_next         = 1'b1;
                res_next.kind       = KIND_CENT;
                res_next.slot       = ADDR_W'(c_reg);
                res_next.out_red    = cent_reg[c_reg][23:16];
                res_next.out_green  = cent_reg[c_reg][15:8];
                res_next.out_blue   = cent_reg[c_reg][7:0];
                res_next.cluster    = c_reg;
                res_next.total_cost = last_c ? cost_reg : '0;
                res_next.last       = last_c;
                if (last_c)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    c_next = c_reg + CL_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a seed write reloads the lfsr
        if (cfg_valid && cfg_ready && cfg_index == REG_SEED)
        begin
            lfsr_next = cfg_data;
        end
    end

    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.kind == KIND_CENT && !result.last |-> busy)
        else $error("centroid transfer ended a run early");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_PICK_WAIT || state_reg == S_DIV_WAIT)
        else $error("divider finished outside a wait state");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_PIXELS))
        else $error("pixel count beyond store depth");

    a_cluster_range: assert property (@(posedge clk) disable iff (!rst_n)
        cl_we |-> {1'b0, cl_wdata} < k_reg)
        else $error("assigned cluster beyond k");
endmodule
